// ===== design/smidt_pkg.sv =====
// ----------------------------------------------------------------------------
// Seen message identifier table package
// Shared types and constants for the duplicate message filter.
// ----------------------------------------------------------------------------
package smidt_pkg;

    // Default number of table slots.
    localparam int unsigned DEF_TABLE_ENTRIES = 64;

    // Field widths fixed by the message format.
    localparam int unsigned ID_HALF_W = 64;
    localparam int unsigned LINK_W    = 10;

    // Operation codes carried in the mode field.
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    // One input beat.
    typedef struct packed {
        logic                 mode;
        logic [ID_HALF_W-1:0] id_high;
        logic [ID_HALF_W-1:0] id_low;
        logic [LINK_W-1:0]    source_link;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic              seen;
        logic [LINK_W-1:0] from_link;
    } result_t;

    // Search token handed from one cell to the next.
    typedef struct packed {
        logic              tok;
        logic              hit;
        logic [LINK_W-1:0] link;
    } chain_t;

endpackage

// ===== design/smidt_cell.sv =====
// ----------------------------------------------------------------------------
// Seen message identifier table cell
// Holds one table slot and passes the search token on to the next cell.
// ----------------------------------------------------------------------------
module smidt_cell
    import smidt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int unsigned IDX           = 0,
    parameter int unsigned SLOT_W        = $clog2(TABLE_ENTRIES)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [SLOT_W-1:0]    wr_slot,
    input  item_t                wr_item,
    input  logic [ID_HALF_W-1:0] key_high,
    input  logic [ID_HALF_W-1:0] key_low,
    input  chain_t               chain_in,
    output chain_t               chain_out
);

    logic                 valid_reg;
    logic [ID_HALF_W-1:0] id_high_reg;
    logic [ID_HALF_W-1:0] id_low_reg;
    logic [LINK_W-1:0]    link_reg;
    logic                 wr_here;
    logic                 match;
    chain_t               chain_reg;
    chain_t               chain_next;

    // A register beat lands in this slot when the write pointer names it.
    assign wr_here = wr_en && (wr_slot == SLOT_W'(IDX));

    // Slot contents carry no reset; only the valid mark is cleared.
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            id_high_reg <= wr_item.id_high;
            id_low_reg  <= wr_item.id_low;
            link_reg    <= wr_item.source_link;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Compare the broadcast key with this slot.
    assign match = valid_reg && (id_high_reg == key_high) && (id_low_reg == key_low);

    // An earlier hit from a lower slot is kept; otherwise this slot may claim it.
    always_comb
    begin
        chain_next = chain_in;
        if (chain_in.tok && !chain_in.hit && match)
        begin
            chain_next.hit  = 1'b1;
            chain_next.link = link_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

// ===== design/seen_message_id_table_core.sv =====
// ----------------------------------------------------------------------------
// Seen message identifier table core
// Round-robin table of recent message identifiers with a search chain that
// reports whether an identifier was seen and on which connection.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload    Direction
//  input     start, busy         item       in
//  result    done (strobe)       result     out
//
//  A register beat is taken at the accepting edge, writes its slot there and
//  does not raise busy. A check beat passes a token through TABLE_ENTRIES
//  cells, one per cycle, after a launch register; done rises as the token
//  enters the last cell's register, and busy, high from the accepting edge,
//  falls at that same edge, so a check holds the input side until then.
//  Reset clears all valid marks, the write pointer and any search in flight.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module seen_message_id_table_core
    import smidt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);

    logic                 accept;
    logic                 wr_en;
    logic                 chk_en;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 launch_reg;
    logic [ID_HALF_W-1:0] key_high_reg;
    logic [ID_HALF_W-1:0] key_low_reg;
    chain_t               chain [TABLE_ENTRIES+1];

    assign accept = start && !busy_reg;
    assign wr_en  = accept && (item.mode == MODE_REGISTER);
    assign chk_en = accept && (item.mode == MODE_CHECK);

    // Write pointer advances round-robin on each register beat.
    always_comb
    begin
        slot_next = slot_reg;
        if (wr_en)
        begin
            if (slot_reg == SLOT_W'(TABLE_ENTRIES - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
        end
    end

    // Busy runs from check accept until the token leaves the last cell.
    always_comb
    begin
        busy_next = busy_reg;
        if (chk_en)
        begin
            busy_next = 1'b1;
        end
        else if (chain[TABLE_ENTRIES-1].tok)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= '0;
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            busy_reg   <= busy_next;
            launch_reg <= chk_en;
        end
    end

    // The search key is held for the whole scan.
    always_ff @(posedge clk)
    begin
        if (chk_en)
        begin
            key_high_reg <= item.id_high;
            key_low_reg  <= item.id_low;
        end
    end

    // The token enters the first cell with no hit recorded.
    always_comb
    begin
        chain[0]      = '0;
        chain[0].tok  = launch_reg;
    end

    // Row of cells, slot 0 first so the lowest matching slot wins.
    for (genvar k = 0; k < TABLE_ENTRIES; k++)
    begin : g_cell
        smidt_cell #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .IDX           (k),
            .SLOT_W        (SLOT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en),
            .wr_slot   (slot_reg),
            .wr_item   (item),
            .key_high  (key_high_reg),
            .key_low   (key_low_reg),
            .chain_in  (chain[k]),
            .chain_out (chain[k+1])
        );
    end

    // The last cell's register is the result beat.
    assign busy             = busy_reg;
    assign done             = chain[TABLE_ENTRIES].tok;
    assign result.seen      = chain[TABLE_ENTRIES].hit;
    assign result.from_link = chain[TABLE_ENTRIES].link;

`ifndef SYNTH
    // A result appears only once the scan has released the input side.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A result always follows a busy scan.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a scan");

    // A miss reports no connection.
    a_miss_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.seen) |-> (result.from_link == '0))
        else $error("miss carries a connection");

    // An accepted check starts a scan.
    a_check_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == MODE_CHECK)) |=> busy)
        else $error("check accepted without scan");
`endif

endmodule

// ===== bench/tb_seen_message_id_table_core.sv =====
// ----------------------------------------------------------------------------
// Seen message identifier table core testbench
// Drives register and check beats into the table through the start/busy
// handshake and tracks its own copy of the slots and write pointer. Each check
// result is compared with the oldest outstanding verdict. The run starts with
// a short table of hand-picked beats and then moves on to random traffic in
// phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_seen_message_id_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import smidt_pkg::*;

    localparam int unsigned TABLE_ENTRIES  = DEF_TABLE_ENTRIES;
    localparam int unsigned RAND_PER_PHASE = 446;
    localparam int unsigned HISTORY_DEPTH  = 256;
    localparam int unsigned DRAIN_CYCLES   = TABLE_ENTRIES + 8;
    localparam int unsigned LIMIT_CYCLES   = 1000000;

    // One 128-bit message identifier.
    typedef struct packed {
        logic [ID_HALF_W-1:0] hi;
        logic [ID_HALF_W-1:0] lo;
    } msg_id_t;

    // One row of the directed stimulus table.
    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Shadow copy of the table.
    logic [ID_HALF_W-1:0] shadow_hi    [TABLE_ENTRIES];
    logic [ID_HALF_W-1:0] shadow_lo    [TABLE_ENTRIES];
    logic [LINK_W-1:0]    shadow_link  [TABLE_ENTRIES];
    bit                   shadow_valid [TABLE_ENTRIES];
    int unsigned          shadow_slot;

    result_t     pending_verdicts [$];
    msg_id_t     id_history [$];
    dir_row_t    directed_rows [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    seen_message_id_table_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #1 clk = ~clk;

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Clear the valid marks and the write pointer, as reset does.
    function automatic void clear_shadow();
        for (int k = 0; k < TABLE_ENTRIES; k++)
            shadow_valid[k] = 1'b0;
        shadow_slot = 0;
    endfunction

    // Store an identifier in the next slot and advance round-robin.
    function automatic void store_id(input item_t beat);
        shadow_hi[shadow_slot]    = beat.id_high;
        shadow_lo[shadow_slot]    = beat.id_low;
        shadow_link[shadow_slot]  = beat.source_link;
        shadow_valid[shadow_slot] = 1'b1;
        shadow_slot = (shadow_slot == TABLE_ENTRIES - 1) ? 0 : shadow_slot + 1;
    endfunction

    // Search the valid slots; the lowest-numbered match answers.
    function automatic result_t lookup_seen(input logic [ID_HALF_W-1:0] hi,
                                            input logic [ID_HALF_W-1:0] lo);
        result_t verdict;
        verdict = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (shadow_valid[k] && shadow_hi[k] == hi && shadow_lo[k] == lo)
            begin
                verdict.seen      = 1'b1;
                verdict.from_link = shadow_link[k];
                return verdict;
            end
        end
        return verdict;
    endfunction

    function automatic dir_row_t row(input logic m, input logic [ID_HALF_W-1:0] hi,
                                     input logic [ID_HALF_W-1:0] lo,
                                     input logic [LINK_W-1:0] link, input bit typed,
                                     input logic seen, input logic [LINK_W-1:0] from_link);
        dir_row_t r;
        r.beat.mode        = m;
        r.beat.id_high     = hi;
        r.beat.id_low      = lo;
        r.beat.source_link = link;
        r.typed            = typed;
        r.want.seen        = seen;
        r.want.from_link   = from_link;
        return r;
    endfunction

    // Extreme or random half of an identifier.
    function automatic logic [ID_HALF_W-1:0] edge_half();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1;
            3:       return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random beat: registers mostly fresh identifiers; checks mostly recent
    // ones, with fresh ones, near misses and long-evicted ones mixed in.
    function automatic item_t random_beat();
        item_t       b;
        msg_id_t     p;
        int unsigned n;
        int unsigned pick;
        int unsigned span;
        n    = id_history.size();
        pick = $urandom_range(99);
        b.mode        = ($urandom_range(99) < 45) ? MODE_REGISTER : MODE_CHECK;
        b.source_link = ($urandom_range(9) == 0) ? '0 : LINK_W'($urandom_range(1023));
        b.id_high     = {$urandom, $urandom};
        b.id_low      = {$urandom, $urandom};
        if (b.mode == MODE_REGISTER)
        begin
            if (pick < 15 && n > 0)
            begin
                p = id_history[$urandom_range(n - 1)];
                b.id_high = p.hi;
                b.id_low  = p.lo;
            end
            else if (pick < 25)
            begin
                b.id_high = edge_half();
                b.id_low  = edge_half();
            end
        end
        else if (n > 0 && pick < 85)
        begin
            span = (n < TABLE_ENTRIES) ? n - 1 : TABLE_ENTRIES - 1;
            if (pick < 55 || pick >= 70)
                p = id_history[n - 1 - $urandom_range(span)];
            else
                p = id_history[$urandom_range(n - 1)];
            if (pick >= 70)
            begin
                if ($urandom_range(1))
                    p.hi ^= 64'(1) << $urandom_range(63);
                else
                    p.lo ^= 64'(1) << $urandom_range(63);
            end
            b.id_high = p.hi;
            b.id_low  = p.lo;
        end
        else if (pick < 92)
        begin
            b.id_high = edge_half();
            b.id_low  = edge_half();
        end
        return b;
    endfunction

    // Number of idle cycles before the next beat.
    function automatic int unsigned sender_gap(input int unsigned idle_pct);
        int unsigned g;
        g = 0;
        while (g < 40 && $urandom_range(99) < idle_pct)
            g++;
        return g;
    endfunction

    // Offer one beat and wait until the table takes it.
    task automatic send_beat(input item_t beat, input bit typed, input result_t want,
                             input int unsigned idle_pct);
        int unsigned gap;
        msg_id_t     p;
        gap = sender_gap(idle_pct);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        // The beat is taken at this edge.
        if (beat.mode == MODE_CHECK)
        begin
            pending_verdicts.push_back(typed ? want : lookup_seen(beat.id_high, beat.id_low));
        end
        else
        begin
            store_id(beat);
            p.hi = beat.id_high;
            p.lo = beat.id_low;
            id_history.push_back(p);
            if (id_history.size() > HISTORY_DEPTH)
                void'(id_history.pop_front());
        end
    endtask

    // Compare each result beat with the oldest outstanding verdict.
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got seen=%0b from_link=%0d",
                         $time, result.seen, result.from_link);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.seen !== want.seen)
                begin
                    $display("%0t: seen mismatch: expected %0b, got %0b",
                             $time, want.seen, result.seen);
                    fail_count++;
                end
                if (result.from_link !== want.from_link)
                begin
                    $display("%0t: from_link mismatch: expected %0d, got %0d",
                             $time, want.from_link, result.from_link);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned idle_pcts [3];
        idle_pcts = '{0, 87, 37};
        clear_shadow();

        // Directed beats: empty table, extreme identifiers, local origin,
        // duplicate registration and near misses.
        directed_rows = '{
            row(MODE_CHECK,    '0, '0, '0, 1, 1'b0, '0),
            row(MODE_CHECK,    '1, '1, '1, 1, 1'b0, '0),
            row(MODE_REGISTER, '1, '1, 10'd1023, 0, 1'b0, '0),
            row(MODE_CHECK,    '1, '1, '0, 1, 1'b1, 10'd1023),
            row(MODE_REGISTER, '0, '0, 10'd0, 0, 1'b0, '0),
            row(MODE_CHECK,    '0, '0, '0, 1, 1'b1, 10'd0),
            row(MODE_CHECK,    '0, 64'd1, '0, 1, 1'b0, '0),
            row(MODE_REGISTER, 64'h8000_0000_0000_0000, 64'd1, 10'd5, 0, 1'b0, '0),
            row(MODE_REGISTER, 64'h8000_0000_0000_0000, 64'd1, 10'd7, 0, 1'b0, '0),
            row(MODE_CHECK,    64'h8000_0000_0000_0000, 64'd1, '0, 1, 1'b1, 10'd5),
            row(MODE_CHECK,    64'h8000_0000_0000_0000, '0, '0, 1, 1'b0, '0),
            row(MODE_CHECK,    '1, '0, '0, 1, 1'b0, '0),
            row(MODE_REGISTER, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                10'd512, 0, 1'b0, '0),
            row(MODE_CHECK,    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                '0, 0, 1'b0, '0),
            row(MODE_REGISTER, '0, '0, 10'd300, 0, 1'b0, '0),
            row(MODE_CHECK,    '0, '0, '0, 1, 1'b1, 10'd0),
            row(MODE_CHECK,    '0, '0, 10'd1023, 1, 1'b1, 10'd0),
            row(MODE_REGISTER, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                10'h2aa, 0, 1'b0, '0),
            row(MODE_CHECK,    64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                '0, 0, 1'b0, '0),
            row(MODE_CHECK,    64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
                '0, 0, 1'b0, '0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed,
                      directed_rows[i].want, 0);

        // Random traffic, one phase per idling level.
        foreach (idle_pcts[ph])
        begin
            for (int unsigned n = 0; n < RAND_PER_PHASE; n++)
                send_beat(random_beat(), 1'b0, '0, idle_pcts[ph]);
        end

        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/smidt_pkg.sv
design/smidt_cell.sv
design/seen_message_id_table_core.sv
bench/tb_seen_message_id_table_core.sv
